// File: sv/lmct_pkg.sv
// Package with the shared types, codes and direction helpers of the contour tracer.
`default_nettype none

package lmct_pkg;

  // Default frame limits handed to the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Fixed widths of the configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COLOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Input operation codes.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  // Input transaction payload.
  typedef struct packed {
    logic       func;
    logic [7:0] pixel_value;
  } item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] point_x;
    logic [7:0] point_y;
    logic       point_valid;
    logic       contour_closed;
  } result_t;

  // Moore neighborhood directions, clockwise from north; y grows southward.
  typedef logic [2:0] dir_t;
  localparam dir_t DIR_N  = 3'd0;
  localparam dir_t DIR_NE = 3'd1;
  localparam dir_t DIR_E  = 3'd2;
  localparam dir_t DIR_SE = 3'd3;
  localparam dir_t DIR_S  = 3'd4;
  localparam dir_t DIR_SW = 3'd5;
  localparam dir_t DIR_W  = 3'd6;
  localparam dir_t DIR_NW = 3'd7;

  // Offset added to the last move direction to start the clockwise search.
  localparam dir_t DIR_BACKTRACK = 3'd5;

  // Per-axis step codes.
  typedef enum logic [1:0] {
    STEP_NONE = 2'b00,
    STEP_POS  = 2'b01,
    STEP_NEG  = 2'b10
  } step_t;

  // Tracing progress kept between requests.
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_TRACE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  // Column step of a direction.
  function automatic step_t dir_step_x(input dir_t dir);
    step_t s;
    case (dir) inside
      DIR_NE, DIR_E, DIR_SE: s = STEP_POS;
      DIR_SW, DIR_W, DIR_NW: s = STEP_NEG;
      default:               s = STEP_NONE;
    endcase
    return s;
  endfunction

  // Row step of a direction.
  function automatic step_t dir_step_y(input dir_t dir);
    step_t s;
    case (dir) inside
      DIR_NW, DIR_N, DIR_NE: s = STEP_NEG;
      DIR_SE, DIR_S, DIR_SW: s = STEP_POS;
      default:               s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: sv/lmct_mask_mem.sv
// One-bit shape mask memory with one write port and one registered read port.
`default_nettype none

module lmct_mask_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);

  logic mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_bit <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: sv/lmct_addr_unit.sv
// Shared multiply-add unit: registered width * b + c, used for frame sizes and mask addresses.
`default_nettype none

module lmct_addr_unit #(
  parameter int WW = 9,
  parameter int HW = 9,
  parameter int XW = 8,
  parameter int PW = 17
) (
  input  logic          clk,
  input  logic [WW-1:0] width,
  input  logic [HW-1:0] mul_b,
  input  logic [XW-1:0] add_c,
  output logic [PW-1:0] result
);

  logic [WW+HW-1:0] prod;

  // Product of the frame width and the row operand.
  assign prod = width * mul_b;

  // Offset added, then registered.
  always_ff @(posedge clk) begin
    result <= PW'(prod) + PW'(add_c);
  end

endmodule

`default_nettype wire

// File: sv/level_mask_contour_tracer_unit.sv
// Top level of the level-mask contour tracer: registers, sequencer and output stage.
//
//  Channel  Signals                          Direction  Payload
//  item     item_valid, item_ready, item     in         lmct_pkg::item_t
//  result   result_valid, result_ready, result out      lmct_pkg::result_t
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  in   register index, write data
//
//  A load transaction runs through accept, frame size product and mask write.
//  The first point request scans the mask in raster order, taking each pixel
//  through address product, mask read and test.
//  Later requests try up to eight neighbors; an out-of-frame neighbor is skipped
//  without a mask read, an in-frame one goes through address product, mask read, test.
//  The shared multiply-add unit and the single mask read port serialize these steps.
//  item_ready is high only while the sequencer is idle; a finished result waits in
//  the output register, and a new result waits for it to be taken. Reset needs no
//  clearing pass; the mask holds whatever was loaded.
`default_nettype none

module level_mask_contour_tracer_unit #(
  parameter int MAX_WIDTH  = lmct_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lmct_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  lmct_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output lmct_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lmct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmct_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import lmct_pkg::*;

  // Derived widths.
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CWW   = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int CWH   = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

  // Sequencer states.
  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_LD_MUL  = 10'b0000000010,
    S_LD_WR   = 10'b0000000100,
    S_SC_MUL  = 10'b0000001000,
    S_SC_RD   = 10'b0000010000,
    S_SC_CHK  = 10'b0000100000,
    S_TR_STEP = 10'b0001000000,
    S_TR_RD   = 10'b0010000000,
    S_TR_CHK  = 10'b0100000000,
    S_EMIT    = 10'b1000000000
  } state_t;

  state_t                  state;
  logic [7:0]              level_color;
  logic [CFG_DATA_W-1:0]   frame_width;
  logic [CFG_DATA_W-1:0]   frame_height;
  logic [AW-1:0]           load_address;
  logic                    pix_hit;
  phase_t                  trace_phase;
  logic [XW-1:0]           start_x;
  logic [YW-1:0]           start_y;
  logic [XW-1:0]           current_x;
  logic [YW-1:0]           current_y;
  logic [XW-1:0]           probe_x;
  logic [YW-1:0]           probe_y;
  dir_t                    last_move_dir;
  dir_t                    try_dir;
  logic [2:0]              tries;
  result_t                 pending;

  logic [CWW-1:0]          fw_ext;
  logic [CWW-1:0]          ew_ext;
  logic [CWH-1:0]          fh_ext;
  logic [CWH-1:0]          eh_ext;
  logic [WW-1:0]           eff_w;
  logic [HW-1:0]           eff_h;
  logic [HW-1:0]           unit_b;
  logic [XW-1:0]           unit_c;
  logic [PW-1:0]           unit_q;
  logic                    mask_bit;
  logic                    mem_wr_en;
  logic [AW-1:0]           wr_addr;
  logic [PW-1:0]           la_ext;
  logic [PW-1:0]           la_inc;
  logic [AW-1:0]           load_address_next;
  logic [WW-1:0]           nx_ext;
  logic [HW-1:0]           ny_ext;
  logic                    nx_neg;
  logic                    ny_neg;
  logic                    in_frame;
  step_t                   sx;
  step_t                   sy;
  logic                    item_fire;
  logic                    out_free;

  assign item_ready = (state == S_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || result_ready;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_color  <= '0;
      frame_width  <= CFG_DATA_W'(256);
      frame_height <= CFG_DATA_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL_COLOR:  level_color  <= cfg_data[7:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, large values clamp to the maximum.
  always_comb begin
    fw_ext = CWW'(frame_width);
    fh_ext = CWH'(frame_height);
    if (fw_ext == '0) begin
      ew_ext = CWW'(1);
    end else if (fw_ext > CWW'(MAX_WIDTH)) begin
      ew_ext = CWW'(MAX_WIDTH);
    end else begin
      ew_ext = fw_ext;
    end
    if (fh_ext == '0) begin
      eh_ext = CWH'(1);
    end else if (fh_ext > CWH'(MAX_HEIGHT)) begin
      eh_ext = CWH'(MAX_HEIGHT);
    end else begin
      eh_ext = fh_ext;
    end
  end

  assign eff_w = ew_ext[WW-1:0];
  assign eff_h = eh_ext[HW-1:0];

  // Neighbor coordinates for the current trial direction, with frame bounds.
  always_comb begin
    sx     = dir_step_x(try_dir);
    sy     = dir_step_y(try_dir);
    nx_ext = WW'(current_x);
    ny_ext = HW'(current_y);
    nx_neg = 1'b0;
    ny_neg = 1'b0;
    case (sx)
      STEP_POS: nx_ext = WW'(current_x) + WW'(1);
      STEP_NEG: begin
        nx_ext = WW'(current_x) - WW'(1);
        nx_neg = (current_x == '0);
      end
      default:  ;
    endcase
    case (sy)
      STEP_POS: ny_ext = HW'(current_y) + HW'(1);
      STEP_NEG: begin
        ny_ext = HW'(current_y) - HW'(1);
        ny_neg = (current_y == '0);
      end
      default:  ;
    endcase
    in_frame = !nx_neg && !ny_neg && (nx_ext < eff_w) && (ny_ext < eff_h);
  end

  // Operand selection for the shared unit.
  always_comb begin
    unique case (state)
      S_LD_MUL: begin
        unit_b = eff_h;
        unit_c = '0;
      end
      S_TR_STEP: begin
        unit_b = HW'(ny_ext[YW-1:0]);
        unit_c = nx_ext[XW-1:0];
      end
      default: begin
        unit_b = HW'(current_y);
        unit_c = current_x;
      end
    endcase
  end

  lmct_addr_unit #(
    .WW (WW),
    .HW (HW),
    .XW (XW),
    .PW (PW)
  ) u_addr (
    .clk    (clk),
    .width  (eff_w),
    .mul_b  (unit_b),
    .add_c  (unit_c),
    .result (unit_q)
  );

  // Load address wrap against the frame size held in the unit register.
  always_comb begin
    la_ext  = PW'(load_address);
    wr_addr = (la_ext >= unit_q) ? '0 : load_address;
    la_inc  = PW'(wr_addr) + PW'(1);
    load_address_next = (la_inc >= unit_q) ? '0 : la_inc[AW-1:0];
  end

  assign mem_wr_en = (state == S_LD_WR);

  lmct_mask_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mask (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_addr),
    .wr_bit  (pix_hit),
    .rd_addr (unit_q[AW-1:0]),
    .rd_bit  (mask_bit)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_address  <= '0;
      trace_phase   <= PH_FIRST;
      start_x       <= '0;
      start_y       <= '0;
      current_x     <= '0;
      current_y     <= '0;
      last_move_dir <= DIR_E;
      try_dir       <= DIR_N;
      tries         <= '0;
      result_valid  <= 1'b0;
    end else begin
      // The emit state refills the output register itself in the cycle it is taken.
      if (result_valid && result_ready && state != S_EMIT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_fire) begin
            pix_hit <= (item.pixel_value == level_color);
            if (item.func == FUNC_LOAD) begin
              state <= S_LD_MUL;
            end else begin
              unique case (trace_phase)
                PH_FIRST: begin
                  current_x <= '0;
                  current_y <= '0;
                  state     <= S_SC_MUL;
                end
                PH_TRACE: begin
                  try_dir <= last_move_dir + DIR_BACKTRACK;
                  tries   <= '0;
                  state   <= S_TR_STEP;
                end
                default: begin
                  pending <= '{point_x: '0, point_y: '0, point_valid: 1'b0,
                               contour_closed: 1'b1};
                  state   <= S_EMIT;
                end
              endcase
            end
          end
        end
        S_LD_MUL: begin
          state <= S_LD_WR;
        end
        S_LD_WR: begin
          load_address <= load_address_next;
          trace_phase  <= PH_FIRST;
          state        <= S_IDLE;
        end
        S_SC_MUL: begin
          state <= S_SC_RD;
        end
        S_SC_RD: begin
          state <= S_SC_CHK;
        end
        S_SC_CHK: begin
          // Raster scan for the first set pixel.
          if (mask_bit) begin
            start_x       <= current_x;
            start_y       <= current_y;
            last_move_dir <= DIR_E;
            trace_phase   <= PH_TRACE;
            pending       <= '{point_x: 8'(current_x), point_y: 8'(current_y),
                              point_valid: 1'b1, contour_closed: 1'b0};
            state         <= S_EMIT;
          end else if (WW'(current_x) + WW'(1) >= eff_w) begin
            current_x <= '0;
            if (HW'(current_y) + HW'(1) >= eff_h) begin
              trace_phase <= PH_DONE;
              pending     <= '{point_x: '0, point_y: '0, point_valid: 1'b0,
                               contour_closed: 1'b1};
              state       <= S_EMIT;
            end else begin
              current_y <= current_y + YW'(1);
              state     <= S_SC_MUL;
            end
          end else begin
            current_x <= current_x + XW'(1);
            state     <= S_SC_MUL;
          end
        end
        S_TR_STEP: begin
          // Neighbors outside the frame are skipped without a mask read.
          probe_x <= nx_ext[XW-1:0];
          probe_y <= ny_ext[YW-1:0];
          if (in_frame) begin
            state <= S_TR_RD;
          end else if (tries == 3'd7) begin
            trace_phase <= PH_DONE;
            pending     <= '{point_x: '0, point_y: '0, point_valid: 1'b0,
                             contour_closed: 1'b1};
            state       <= S_EMIT;
          end else begin
            try_dir <= try_dir + dir_t'(1);
            tries   <= tries + 3'd1;
          end
        end
        S_TR_RD: begin
          state <= S_TR_CHK;
        end
        S_TR_CHK: begin
          if (mask_bit) begin
            if (probe_x == start_x && probe_y == start_y) begin
              trace_phase <= PH_DONE;
              pending     <= '{point_x: '0, point_y: '0, point_valid: 1'b0,
                               contour_closed: 1'b1};
            end else begin
              current_x     <= probe_x;
              current_y     <= probe_y;
              last_move_dir <= try_dir;
              pending       <= '{point_x: 8'(probe_x), point_y: 8'(probe_y),
                                 point_valid: 1'b1, contour_closed: 1'b0};
            end
            state <= S_EMIT;
          end else if (tries == 3'd7) begin
            // Isolated pixel: no set neighbor closes the contour.
            trace_phase <= PH_DONE;
            pending     <= '{point_x: '0, point_y: '0, point_valid: 1'b0,
                             contour_closed: 1'b1};
            state       <= S_EMIT;
          end else begin
            try_dir <= try_dir + dir_t'(1);
            tries   <= tries + 3'd1;
            state   <= S_TR_STEP;
          end
        end
        S_EMIT: begin
          // Hand the result to the output register once it is free.
          if (out_free) begin
            result       <= pending;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sim/level_mask_contour_tracer_unit_test.sv
// Testbench for the level-mask contour tracer: random frames, predicted contour points, checks.
`timescale 1ns / 100ps

module level_mask_contour_tracer_unit_test;
  import lmct_pkg::*;

  localparam int MAX_COLS = MAX_WIDTH_DEF;
  localparam int MAX_ROWS = MAX_HEIGHT_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  level_mask_contour_tracer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Mirror of the tracer's registers and tracing state.
  logic [7:0] level_reg = 8'd0;
  logic [8:0] width_reg = 9'd256;
  logic [8:0] height_reg = 9'd256;
  bit mask_bits [MAX_COLS*MAX_ROWS];
  int load_ptr = 0;
  int origin_x = 0;
  int origin_y = 0;
  int at_x = 0;
  int at_y = 0;
  dir_t heading = DIR_E;
  phase_t trace_state = PH_FIRST;

  item_t pending_items [$];
  result_t expected_points [$];
  result_t want;
  result_t predicted;
  int items_taken = 0;
  int fault_count = 0;
  int pushed = 0;
  bit item_fire = 1'b0;
  bit cfg_fire = 1'b0;

  // Clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40_000_000;
    $display("level_mask_contour_tracer_unit_test: errors");
    $finish;
  end

  // A size register of 0 acts as 1, and anything above the limit acts as the limit.
  function automatic int frame_dim(input logic [8:0] raw, input int limit);
    if (raw == 9'd0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // Column and row offsets of a neighbor direction; rows grow southward.
  function automatic void neighbor_offset(input dir_t d, output int dx, output int dy);
    case (d)
      DIR_N:   begin dx = 0;  dy = -1; end
      DIR_NE:  begin dx = 1;  dy = -1; end
      DIR_E:   begin dx = 1;  dy = 0;  end
      DIR_SE:  begin dx = 1;  dy = 1;  end
      DIR_S:   begin dx = 0;  dy = 1;  end
      DIR_SW:  begin dx = -1; dy = 1;  end
      DIR_W:   begin dx = -1; dy = 0;  end
      default: begin dx = -1; dy = -1; end
    endcase
  endfunction

  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LEVEL_COLOR:  level_reg = data[7:0];
      CFG_FRAME_WIDTH:  width_reg = data;
      CFG_FRAME_HEIGHT: height_reg = data;
      default: ;
    endcase
  endfunction

  // Applies one transaction to the mirror; returns 1 with the point it emits, if any.
  function automatic bit next_contour_point(input item_t it, output result_t pt);
    int w, h, total, x, y, nx, ny, dx, dy, tries;
    dir_t d;
    pt = '0;
    w = frame_dim(width_reg, MAX_COLS);
    h = frame_dim(height_reg, MAX_ROWS);
    total = w * h;
    if (it.func == FUNC_LOAD) begin
      if (load_ptr >= total) load_ptr = 0;
      mask_bits[load_ptr] = (it.pixel_value == level_reg);
      load_ptr = (load_ptr + 1 >= total) ? 0 : load_ptr + 1;
      trace_state = PH_FIRST;
      return 1'b0;
    end
    // Every path that does not emit a point reports a closed contour.
    pt.contour_closed = 1'b1;
    if (trace_state == PH_FIRST) begin
      for (y = 0; y < h; y++) begin
        for (x = 0; x < w; x++) begin
          if (mask_bits[y*w + x]) begin
            origin_x = x;
            origin_y = y;
            at_x = x;
            at_y = y;
            heading = DIR_E;
            trace_state = PH_TRACE;
            pt.point_x = 8'(x);
            pt.point_y = 8'(y);
            pt.point_valid = 1'b1;
            pt.contour_closed = 1'b0;
            return 1'b1;
          end
        end
      end
      trace_state = PH_DONE;
      return 1'b1;
    end
    if (trace_state == PH_TRACE) begin
      // Clockwise search starting just past the pixel we came from.
      d = heading + DIR_BACKTRACK;
      for (tries = 0; tries < 8; tries++) begin
        neighbor_offset(d, dx, dy);
        nx = at_x + dx;
        ny = at_y + dy;
        if (nx >= 0 && ny >= 0 && nx < w && ny < h && mask_bits[ny*w + nx]) begin
          if (nx == origin_x && ny == origin_y) begin
            trace_state = PH_DONE;
            return 1'b1;
          end
          at_x = nx;
          at_y = ny;
          heading = d;
          pt.point_x = 8'(nx);
          pt.point_y = 8'(ny);
          pt.point_valid = 1'b1;
          pt.contour_closed = 1'b0;
          return 1'b1;
        end
        d = d + 3'd1;
      end
      // No set neighbor: the pixel stands alone.
      trace_state = PH_DONE;
    end
    return 1'b1;
  endfunction

  // Percent of cycles in which a side holds off, by progress through the run.
  function automatic int gap_pct(input bit sender_side);
    if (items_taken < 550) return sender_side ? 38 : 48;
    if (items_taken < 1100) return sender_side ? 48 : 38;
    return 0;
  endfunction

  function automatic logic [7:0] noise_byte(input logic [7:0] lvl);
    logic [7:0] v;
    v = 8'($urandom_range(255));
    return (v == lvl) ? (v ^ 8'h01) : v;
  endfunction

  // Driver: record accepted transactions and predict their results at the rising edge.
  always @(posedge clk) begin
    item_fire = !rst && item_valid && item_ready;
    cfg_fire = !rst && cfg_valid && cfg_ready;
    if (cfg_fire) write_register(cfg_index, cfg_data);
    if (item_fire) begin
      items_taken++;
      if (next_contour_point(item, predicted)) expected_points = {expected_points, predicted};
    end
  end

  // Driver: present the next pending item at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct(1'b1)) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest predicted point.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_points.size() == 0) begin
        $error("result with no point outstanding: x %0d y %0d valid %0d closed %0d",
               result.point_x, result.point_y, result.point_valid, result.contour_closed);
        fault_count++;
      end else begin
        want = expected_points.pop_front();
        if (result.point_x !== want.point_x) begin
          $error("point_x: expected %0d, got %0d", want.point_x, result.point_x);
          fault_count++;
        end
        if (result.point_y !== want.point_y) begin
          $error("point_y: expected %0d, got %0d", want.point_y, result.point_y);
          fault_count++;
        end
        if (result.point_valid !== want.point_valid) begin
          $error("point_valid: expected %0d, got %0d", want.point_valid, result.point_valid);
          fault_count++;
        end
        if (result.contour_closed !== want.contour_closed) begin
          $error("contour_closed: expected %0d, got %0d",
                 want.contour_closed, result.contour_closed);
          fault_count++;
        end
      end
    end
  end

  // Driver: random back-pressure on the result channel.
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= gap_pct(1'b0));
  end

  task automatic queue_item(input logic f, input logic [7:0] v);
    item_t it;
    it.func = f;
    it.pixel_value = v;
    pending_items = {pending_items, it};
    pushed++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid = 1'b0;
  endtask

  // Hold the sender until every item is taken and every point has come back,
  // then give a trailing load time to finish its mask write. The check runs at
  // the rising edge, where the driver's falling-edge updates have settled.
  task automatic wait_for_quiet();
    do @(posedge clk);
    while (pending_items.size() != 0 || item_valid || expected_points.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Stimulus.
  initial begin : stimulus
    int w, h, total, addr, x, y, x0, x1, y0, y1, dens, n, k, frame_no, i;
    logic [7:0] lvl;
    logic [8:0] raw;
    logic [8:0] plus_shape;
    bit lit;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Plus shape on a 3x3 frame with the top level 0xFF.
    cfg_write(CFG_FRAME_WIDTH, 9'd3);
    cfg_write(CFG_FRAME_HEIGHT, 9'd3);
    cfg_write(CFG_LEVEL_COLOR, 9'h0FF);
    cfg_write(CFG_UNUSED, 9'h1AA);
    @(posedge clk);
    plus_shape = 9'b010_111_010;
    for (i = 0; i < 9; i++) queue_item(FUNC_LOAD, plus_shape[i] ? 8'hFF : 8'h00);
    queue_item(FUNC_REQUEST, 8'h00);
    queue_item(FUNC_REQUEST, 8'h00);
    // A load in the middle of a trace sends the tracer back to the first search.
    queue_item(FUNC_LOAD, 8'h00);
    for (i = 0; i < 7; i++) queue_item(FUNC_REQUEST, 8'h00);

    // Zero sizes act as a 1x1 frame: first no shape, then an isolated pixel.
    wait_for_quiet();
    cfg_write(CFG_FRAME_WIDTH, 9'd0);
    cfg_write(CFG_FRAME_HEIGHT, 9'd0);
    cfg_write(CFG_LEVEL_COLOR, 9'd254);
    @(posedge clk);
    queue_item(FUNC_LOAD, 8'd7);
    queue_item(FUNC_REQUEST, 8'h00);
    queue_item(FUNC_REQUEST, 8'hFF);
    queue_item(FUNC_LOAD, 8'd254);
    queue_item(FUNC_REQUEST, 8'h00);
    queue_item(FUNC_REQUEST, 8'h00);

    // Random frames: full load, then a run of point requests, sometimes touched up.
    frame_no = 0;
    while (pushed < 1600) begin
      wait_for_quiet();
      frame_no++;
      if (frame_no == 3) begin
        cfg_write(CFG_FRAME_WIDTH, 9'd256);
        cfg_write(CFG_FRAME_HEIGHT, 9'd1);
      end else if (frame_no == 6) begin
        cfg_write(CFG_FRAME_WIDTH, 9'd1);
        cfg_write(CFG_FRAME_HEIGHT, 9'h1FF);
      end else if (frame_no == 4 || frame_no == 7 || $urandom_range(1) == 1) begin
        cfg_write(CFG_FRAME_WIDTH, 9'($urandom_range(12)));
        cfg_write(CFG_FRAME_HEIGHT, 9'($urandom_range(12)));
      end
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(7))
          0: lvl = 8'h00;
          1: lvl = 8'hFE;
          2: lvl = 8'hFF;
          default: lvl = 8'($urandom_range(255));
        endcase
        raw = 9'($urandom_range(511));
        raw[7:0] = lvl;
        cfg_write(CFG_LEVEL_COLOR, raw);
      end
      if ($urandom_range(7) == 0) cfg_write(CFG_UNUSED, 9'($urandom_range(511)));
      @(posedge clk);

      w = frame_dim(width_reg, MAX_COLS);
      h = frame_dim(height_reg, MAX_ROWS);
      total = w * h;
      lvl = level_reg;
      addr = (load_ptr >= total) ? 0 : load_ptr;

      // Pick a shape: empty, solid box, sparse box, single pixel or noise over the frame.
      x0 = $urandom_range(w - 1);
      x1 = $urandom_range(w - 1, x0);
      y0 = $urandom_range(h - 1);
      y1 = $urandom_range(h - 1, y0);
      case ($urandom_range(5))
        0: dens = 0;
        1: dens = 100;
        2, 3: dens = $urandom_range(90, 30);
        4: begin
          x1 = x0;
          y1 = y0;
          dens = 100;
        end
        default: begin
          x0 = 0;
          x1 = w - 1;
          y0 = 0;
          y1 = h - 1;
          dens = $urandom_range(100);
        end
      endcase

      // Load the whole frame so that every mask entry a request can read is written.
      for (i = 0; i < total; i++) begin
        x = addr % w;
        y = addr / w;
        lit = x >= x0 && x <= x1 && y >= y0 && y <= y1 && $urandom_range(99) < dens;
        queue_item(FUNC_LOAD, lit ? lvl : noise_byte(lvl));
        addr = (addr + 1 >= total) ? 0 : addr + 1;
      end

      if ($urandom_range(9) != 0) begin
        n = 2 * total + 4;
        if (n > 60) n = 60;
        n = $urandom_range(n, 1);
        for (i = 0; i < n; i++) queue_item(FUNC_REQUEST, 8'($urandom_range(255)));
      end

      // Overwrite a few pixels and trace again.
      if ($urandom_range(2) == 0) begin
        k = $urandom_range(3, 1);
        for (i = 0; i < k; i++) queue_item(FUNC_LOAD, $urandom_range(1) ? lvl : noise_byte(lvl));
        n = $urandom_range(12, 1);
        for (i = 0; i < n; i++) queue_item(FUNC_REQUEST, 8'($urandom_range(255)));
      end
    end

    wait_for_quiet();
    if (fault_count == 0) begin
      $display("level_mask_contour_tracer_unit_test: clean");
    end else begin
      $display("level_mask_contour_tracer_unit_test: errors");
    end
    $finish;
  end

endmodule
